// File: hdl/brn_pkg.sv
// ----------------------------------------------------------------------------
// brn_pkg
// shared types and codes for the byte range normalizer
// ----------------------------------------------------------------------------
package brn_pkg;

  localparam int OFS_BITS = 48;
  localparam int DELTA_BITS = OFS_BITS + 1;

  typedef logic [OFS_BITS-1:0] ofs_t;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BOUNDS   = 2'd1;
  localparam logic [1:0] ST_CONFLICT = 2'd2;
  localparam logic [1:0] ST_TOO_MANY = 2'd3;

  // segment kinds
  localparam logic KIND_PAD  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef struct packed {
    ofs_t dst_ofs;
    ofs_t length;
    ofs_t src_ofs;
    logic last_range;
  } rng_t;

  typedef struct packed {
    logic       seg_kind;
    ofs_t       seg_dst_offset;
    ofs_t       seg_length;
    ofs_t       seg_src_offset;
    logic [1:0] status;
    logic       last_segment;
  } seg_t;

  // one stored copy range
  typedef struct packed {
    ofs_t dst;
    ofs_t len;
    ofs_t src;
  } entry_t;

  // one buffered output segment
  typedef struct packed {
    logic kind;
    ofs_t dst;
    ofs_t len;
    ofs_t src;
  } segent_t;

endpackage

// File: hdl/byte_range_normalizer.sv
// ----------------------------------------------------------------------------
// byte_range_normalizer
// turns a set of copy ranges into an ordered, gap-free segment list
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   rng       in         rng_valid/rng_stall  brn_pkg::rng_t
//   seg       out        seg_valid/seg_stall  brn_pkg::seg_t
//   cfg       in         cfg_valid/cfg_ready  space size, always ready
//
// ranges load one per cycle into the range memory until one marked last
// processing then runs pass by pass: each pass scans the memory to pick the next
// range in sort order, then sweeps it into the segment memory
// emitting reads each segment back through the segment memory read port
// rst is synchronous; it clears control state only, memories keep contents
// a stalled result sits in the output register; the final one does not
// block loading of the next set
module byte_range_normalizer #(
  parameter int MAX_RANGES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rng_valid,
  output logic                 rng_stall,
  input  brn_pkg::rng_t        rng,
  output logic                 seg_valid,
  input  logic                 seg_stall,
  output brn_pkg::seg_t        seg,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  brn_pkg::ofs_t        cfg_data
);

  localparam int AW    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW    = $clog2(MAX_RANGES + 1);
  localparam int OD    = 2 * MAX_RANGES + 1;
  localparam int OA    = $clog2(OD);
  localparam int OW    = $clog2(OD + 1);
  localparam int KEY_W = 3 * brn_pkg::OFS_BITS + AW;

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_SCAN  = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_PAD   = 9'b000001000,
    S_DATA  = 9'b000010000,
    S_TAIL  = 9'b000100000,
    S_ERR   = 9'b001000000,
    S_RD    = 9'b010000000,
    S_LD    = 9'b100000000
  } state_t;

  state_t state;

  // configuration
  brn_pkg::ofs_t space_size;

  // loading
  logic [CW-1:0] range_count;
  logic          overflow_flag;

  // selection scan
  logic [CW-1:0]  issue;       // next address to read
  logic           rd_valid;    // read data arrives this cycle
  logic [AW-1:0]  rd_idx;
  logic [CW-1:0]  pass;        // ranges already swept
  logic           have_best;
  logic [KEY_W-1:0] best_key;
  logic [KEY_W-1:0] prev_key;
  brn_pkg::entry_t  best;

  // sweep state
  brn_pkg::ofs_t cursor;
  logic          delta_valid;
  logic [brn_pkg::DELTA_BITS-1:0] run_delta;
  brn_pkg::ofs_t w_dst;
  brn_pkg::ofs_t w_len;
  brn_pkg::ofs_t w_src;
  brn_pkg::ofs_t w_end;
  logic [brn_pkg::DELTA_BITS-1:0] w_delta;
  logic [OW-1:0] seg_count;
  logic [OW-1:0] emit;
  logic [1:0]    err_status;

  // memories
  logic            st_wr_en;
  brn_pkg::entry_t st_wr_data;
  brn_pkg::entry_t st_rd_data;
  logic            sb_wr_en;
  logic [OA-1:0]   sb_wr_addr;
  brn_pkg::segent_t sb_wr_data;
  logic [OA-1:0]   sb_rd_addr;
  brn_pkg::segent_t sb_rd_data;

  logic rng_accept;
  logic out_free;
  logic out_load;

  assign rng_stall  = (state != S_LOAD);
  assign rng_accept = rng_valid && !rng_stall;
  assign cfg_ready  = 1'b1;
  assign out_free   = !seg_valid || !seg_stall;
  // output register takes a new result this cycle
  assign out_load   = ((state == S_ERR) || (state == S_LD)) && out_free;

  assign st_wr_en   = rng_accept && (range_count < CW'(MAX_RANGES));
  assign st_wr_data = '{dst: rng.dst_ofs, len: rng.length, src: rng.src_ofs};

  brn_store #(.DEPTH(MAX_RANGES), .AW(AW)) u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (range_count[AW-1:0]),
    .wr_data (st_wr_data),
    .rd_addr (issue[AW-1:0]),
    .rd_data (st_rd_data)
  );

  brn_segbuf #(.DEPTH(OD), .AW(OA)) u_segbuf (
    .clk     (clk),
    .wr_en   (sb_wr_en),
    .wr_addr (sb_wr_addr),
    .wr_data (sb_wr_data),
    .rd_addr (sb_rd_addr),
    .rd_data (sb_rd_data)
  );

  assign sb_rd_addr = emit[OA-1:0];
  assign sb_wr_addr = seg_count[OA-1:0];

  // segment writes during sweep and tail
  always_comb begin
    sb_wr_en   = 1'b0;
    sb_wr_data = '{kind: brn_pkg::KIND_PAD, dst: cursor, len: w_dst - cursor, src: '0};
    unique case (state)
      S_PAD: begin
        sb_wr_en = 1'b1;
      end
      S_DATA: begin
        sb_wr_en   = 1'b1;
        sb_wr_data = '{kind: brn_pkg::KIND_DATA, dst: w_dst, len: w_len, src: w_src};
      end
      S_TAIL: begin
        sb_wr_en   = (cursor < space_size);
        sb_wr_data = '{kind: brn_pkg::KIND_PAD, dst: cursor, len: space_size - cursor,
                       src: '0};
      end
      default: begin
        sb_wr_en = 1'b0;
      end
    endcase
  end

  // candidate from the scan: key is dst, src, len, index
  logic [KEY_W-1:0] cand_key;
  logic             cand_take;
  assign cand_key  = {st_rd_data.dst, st_rd_data.src, st_rd_data.len, rd_idx};
  assign cand_take = ((pass == '0) || (cand_key > prev_key)) &&
                     (!have_best || (cand_key < best_key));

  // sweep check on the selected range
  brn_pkg::ofs_t b_end;
  logic [brn_pkg::DELTA_BITS-1:0] b_delta;
  assign b_end   = best.dst + best.len;
  assign b_delta = {1'b0, best.src} - {1'b0, best.dst};

  logic last_pass;
  assign last_pass = ((pass + CW'(1)) == range_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      space_size    <= brn_pkg::ofs_t'(1);
      range_count   <= '0;
      overflow_flag <= 1'b0;
      seg_valid     <= 1'b0;
      rd_valid      <= 1'b0;
      issue         <= '0;
      pass          <= '0;
      have_best     <= 1'b0;
      delta_valid   <= 1'b0;
      seg_count     <= '0;
      emit          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        space_size <= cfg_data;
      end
      if (out_load) begin
        seg_valid <= 1'b1;
      end else if (seg_valid && !seg_stall) begin
        seg_valid <= 1'b0;
      end
      rd_valid <= (state == S_SCAN) && (issue < range_count);

      unique case (state)
        S_LOAD: begin
          if (rng_accept) begin
            if (range_count < CW'(MAX_RANGES)) begin
              range_count <= range_count + CW'(1);
            end else begin
              overflow_flag <= 1'b1;
            end
            if (rng.last_range) begin
              cursor      <= '0;
              delta_valid <= 1'b0;
              run_delta   <= '0;
              seg_count   <= '0;
              pass        <= '0;
              issue       <= '0;
              have_best   <= 1'b0;
              if (overflow_flag || (range_count == CW'(MAX_RANGES))) begin
                err_status <= brn_pkg::ST_TOO_MANY;
                state      <= S_ERR;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end

        S_SCAN: begin
          if (issue < range_count) begin
            issue    <= issue + CW'(1);
            rd_idx   <= issue[AW-1:0];
          end
          if (rd_valid && cand_take) begin
            have_best <= 1'b1;
            best_key  <= cand_key;
            best      <= st_rd_data;
          end
          if ((issue == range_count) && !rd_valid) begin
            state <= S_CHECK;
          end
        end

        S_CHECK: begin
          w_end   <= b_end;
          w_delta <= b_delta;
          w_dst   <= best.dst;
          w_len   <= best.len;
          w_src   <= best.src;
          prev_key  <= best_key;
          if (best.len == '0) begin
            // zero-length range, nothing to sweep
            pass      <= pass + CW'(1);
            issue     <= '0;
            have_best <= 1'b0;
            state     <= last_pass ? S_TAIL : S_SCAN;
          end else if ((best.dst >= space_size) || (best.len > space_size - best.dst)) begin
            err_status <= brn_pkg::ST_BOUNDS;
            state      <= S_ERR;
          end else if (best.dst < cursor) begin
            if (delta_valid && (run_delta != b_delta)) begin
              err_status <= brn_pkg::ST_CONFLICT;
              state      <= S_ERR;
            end else if (b_end <= cursor) begin
              // fully covered already
              pass      <= pass + CW'(1);
              issue     <= '0;
              have_best <= 1'b0;
              state     <= last_pass ? S_TAIL : S_SCAN;
            end else begin
              // trim the covered head
              w_dst <= cursor;
              w_len <= b_end - cursor;
              w_src <= best.src + (cursor - best.dst);
              state <= S_DATA;
            end
          end else if (best.dst > cursor) begin
            state <= S_PAD;
          end else begin
            state <= S_DATA;
          end
        end

        S_PAD: begin
          seg_count   <= seg_count + OW'(1);
          delta_valid <= 1'b0;
          cursor      <= w_dst;
          state       <= S_DATA;
        end

        S_DATA: begin
          seg_count    <= seg_count + OW'(1);
          run_delta    <= w_delta;
          delta_valid  <= 1'b1;
          cursor       <= w_end;
          pass         <= pass + CW'(1);
          issue        <= '0;
          have_best    <= 1'b0;
          state        <= last_pass ? S_TAIL : S_SCAN;
        end

        S_TAIL: begin
          emit <= '0;
          if (cursor < space_size) begin
            seg_count <= seg_count + OW'(1);
            state     <= S_RD;
          end else if (seg_count == '0) begin
            // nothing to report for this set
            range_count   <= '0;
            overflow_flag <= 1'b0;
            state         <= S_LOAD;
          end else begin
            state <= S_RD;
          end
        end

        S_ERR: begin
          if (out_free) begin
            seg           <= '{seg_kind: brn_pkg::KIND_PAD, seg_dst_offset: '0,
                               seg_length: '0, seg_src_offset: '0,
                               status: err_status, last_segment: 1'b1};
            range_count   <= '0;
            overflow_flag <= 1'b0;
            state         <= S_LOAD;
          end
        end

        S_RD: begin
          state <= S_LD;
        end

        S_LD: begin
          if (out_free) begin
            seg       <= '{seg_kind: sb_rd_data.kind, seg_dst_offset: sb_rd_data.dst,
                           seg_length: sb_rd_data.len, seg_src_offset: sb_rd_data.src,
                           status: brn_pkg::ST_OK,
                           last_segment: ((emit + OW'(1)) == seg_count)};
            if ((emit + OW'(1)) == seg_count) begin
              range_count   <= '0;
              overflow_flag <= 1'b0;
              state         <= S_LOAD;
            end else begin
              emit  <= emit + OW'(1);
              state <= S_RD;
            end
          end
        end

        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// File: hdl/brn_store.sv
// ----------------------------------------------------------------------------
// brn_store
// range memory, one write and one registered read port
// ----------------------------------------------------------------------------
module brn_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  brn_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output brn_pkg::entry_t rd_data
);

  brn_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/brn_segbuf.sv
// ----------------------------------------------------------------------------
// brn_segbuf
// output segment memory, one write and one registered read port
// ----------------------------------------------------------------------------
module brn_segbuf #(
  parameter int DEPTH = 33,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  brn_pkg::segent_t wr_data,
  input  logic [AW-1:0]    rd_addr,
  output brn_pkg::segent_t rd_data
);

  brn_pkg::segent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/brn_checker.sv
// ----------------------------------------------------------------------------
// brn_checker
// port-level checks for the byte range normalizer
// ----------------------------------------------------------------------------
module brn_checker (
  input logic          clk,
  input logic          rst,
  input logic          rng_stall,
  input logic          seg_valid,
  input logic          seg_stall,
  input brn_pkg::seg_t seg
);

  // a stalled result stays offered
  a_seg_hold: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg_stall |=> seg_valid)
    else $error("result dropped while stalled");

  // an error result closes its set
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    seg_valid && (seg.status != brn_pkg::ST_OK) |-> seg.last_segment)
    else $error("error result not marked last");

  // an error result carries no segment
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    seg_valid && (seg.status != brn_pkg::ST_OK) |->
      (seg.seg_length == '0) && (seg.seg_dst_offset == '0) &&
      (seg.seg_kind == brn_pkg::KIND_PAD))
    else $error("error result carries segment data");

  // pad segments have no source
  a_pad_src: assert property (@(posedge clk) disable iff (rst)
    seg_valid && (seg.seg_kind == brn_pkg::KIND_PAD) |-> (seg.seg_src_offset == '0))
    else $error("pad segment with nonzero source");

  // no range is taken while a segment list is still going out
  a_busy: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg.last_segment |-> rng_stall)
    else $error("range taken in the middle of a segment list");

endmodule

bind byte_range_normalizer brn_checker u_brn_checker (
  .clk       (clk),
  .rst       (rst),
  .rng_stall (rng_stall),
  .seg_valid (seg_valid),
  .seg_stall (seg_stall),
  .seg       (seg)
);

// File: sim/byte_range_normalizer_test.sv
// ----------------------------------------------------------------------------
// byte_range_normalizer_test
// self-checking bench: random and directed range sets against a local model
// ----------------------------------------------------------------------------
module byte_range_normalizer_test;

  localparam int            MAX_RANGES = 16;
  localparam int            SETTLE_CYCLES = 800;   // > one full set of sorting + emitting
  localparam brn_pkg::ofs_t OFS_MAX = '1;

  logic          clk;
  logic          rst;
  logic          rng_valid;
  logic          rng_stall;
  brn_pkg::rng_t rng;
  logic          seg_valid;
  logic          seg_stall;
  brn_pkg::seg_t seg;
  logic          cfg_valid;
  logic          cfg_ready;
  brn_pkg::ofs_t cfg_data;

  byte_range_normalizer #(.MAX_RANGES(MAX_RANGES)) uut (
    .clk(clk), .rst(rst),
    .rng_valid(rng_valid), .rng_stall(rng_stall), .rng(rng),
    .seg_valid(seg_valid), .seg_stall(seg_stall), .seg(seg),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // pending input transactions and expected segment transactions
  brn_pkg::rng_t range_q[$];
  brn_pkg::seg_t segment_q[$];
  int   ranges_queued = 0;
  int   ranges_taken = 0;
  int   errors = 0;

  // model state: collected set, overflow, configured total
  brn_pkg::entry_t set_store[MAX_RANGES];
  int              set_count = 0;
  bit              set_overflow = 1'b0;
  brn_pkg::ofs_t   space_len = 1;

  function automatic brn_pkg::ofs_t rand48();
    return brn_pkg::ofs_t'({$urandom, $urandom});
  endfunction

  function automatic void push_segment(logic kind, logic [63:0] d, logic [63:0] l,
                                       logic [63:0] s, logic [1:0] st);
    brn_pkg::seg_t e;
    e.seg_kind = kind;
    e.seg_dst_offset = d[brn_pkg::OFS_BITS-1:0];
    e.seg_length = l[brn_pkg::OFS_BITS-1:0];
    e.seg_src_offset = s[brn_pkg::OFS_BITS-1:0];
    e.status = st;
    e.last_segment = 1'b0;
    segment_q.insert(segment_q.size(), e);
  endfunction

  // sort the collected set and sweep it into an ordered segment list
  function automatic void normalize_set();
    brn_pkg::entry_t tmp;
    logic [63:0] d, l, s, stop, delta, cur, act;
    bit   dv;
    logic [1:0] st;
    int   first;
    first = segment_q.size();
    st = brn_pkg::ST_OK;
    if (set_overflow) begin
      st = brn_pkg::ST_TOO_MANY;
    end else begin
      for (int i = 1; i < set_count; i++) begin
        for (int j = i; j > 0; j--) begin
          if (set_store[j].dst < set_store[j-1].dst ||
              (set_store[j].dst == set_store[j-1].dst &&
               (set_store[j].src < set_store[j-1].src ||
                (set_store[j].src == set_store[j-1].src &&
                 set_store[j].len < set_store[j-1].len)))) begin
            tmp = set_store[j];
            set_store[j] = set_store[j-1];
            set_store[j-1] = tmp;
          end else begin
            break;
          end
        end
      end
      cur = 0;
      dv = 1'b0;
      act = 0;
      for (int i = 0; i < set_count && st == brn_pkg::ST_OK; i++) begin
        d = 64'(set_store[i].dst);
        l = 64'(set_store[i].len);
        s = 64'(set_store[i].src);
        if (l == 0) continue;
        if (d >= 64'(space_len) || l > 64'(space_len) - d) begin
          st = brn_pkg::ST_BOUNDS;
          break;
        end
        stop = d + l;
        delta = s - d;
        if (d < cur) begin
          if (dv && act != delta) begin
            st = brn_pkg::ST_CONFLICT;
            break;
          end
          if (stop <= cur) continue;
          s = 64'(brn_pkg::ofs_t'(s + (cur - d)));
          d = cur;
          l = stop - cur;
        end
        if (d > cur) begin
          push_segment(brn_pkg::KIND_PAD, cur, d - cur, 0, brn_pkg::ST_OK);
          dv = 1'b0;
          cur = d;
        end
        push_segment(brn_pkg::KIND_DATA, d, l, s, brn_pkg::ST_OK);
        act = delta;
        dv = 1'b1;
        cur = stop;
      end
      if (st == brn_pkg::ST_OK && cur < 64'(space_len))
        push_segment(brn_pkg::KIND_PAD, cur, 64'(space_len) - cur, 0, brn_pkg::ST_OK);
    end
    if (st != brn_pkg::ST_OK) begin
      while (segment_q.size() > first) void'(segment_q.pop_back());
      push_segment(brn_pkg::KIND_PAD, 0, 0, 0, st);
    end
    if (segment_q.size() > first) segment_q[segment_q.size()-1].last_segment = 1'b1;
    set_count = 0;
    set_overflow = 1'b0;
  endfunction

  function automatic void take_range(brn_pkg::rng_t r);
    if (set_count < MAX_RANGES) begin
      set_store[set_count] = '{dst: r.dst_ofs, len: r.length, src: r.src_ofs};
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (r.last_range) normalize_set();
  endfunction

  // driver: bursts of random length separated by random gaps
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    if (rst) begin
      rng_valid <= 1'b0;
      rng <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (rng_valid && !rng_stall) begin
        take_range(rng);
        ranges_taken++;
      end
      if (!rng_valid || !rng_stall) begin
        if (gap_left != 0) begin
          rng_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (range_q.size() != 0) begin
          rng <= range_q.pop_front();
          rng_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          rng_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, picks one of four modes again and again off a free-running counter;
  // twice a long hold-off while the sender has plenty queued
  int cycle_cnt;
  int hold_left;
  int holds_done;
  int stall_mode;

  always @(posedge clk) begin
    if (rst) begin
      seg_stall <= 1'b0;
      cycle_cnt <= 0;
      hold_left <= 0;
      holds_done <= 0;
      stall_mode <= 0;
    end else begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt % 128 == 0) stall_mode <= $urandom_range(0, 3);
      if (hold_left != 0) begin
        seg_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (holds_done < 2 && range_q.size() > 8 && rng_valid) begin
        seg_stall <= 1'b1;
        hold_left <= 600;
        holds_done <= holds_done + 1;
      end else begin
        case (stall_mode)
          0: begin
            seg_stall <= 1'b0;
          end
          1: begin
            seg_stall <= ($urandom_range(0, 3) == 0);
          end
          2: begin
            seg_stall <= ($urandom_range(0, 9) < 7);
          end
          default: begin
            seg_stall <= cycle_cnt[1];
          end
        endcase
      end
    end
  end

  // monitor: compare each segment transaction with the oldest expectation
  always @(posedge clk) begin
    brn_pkg::seg_t want;
    if (!rst && seg_valid && !seg_stall) begin
      if (segment_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected segment %p", seg);
      end else begin
        want = segment_q.pop_front();
        if (seg !== want) begin
          errors++;
          if (errors <= 10) $display("segment mismatch: expected %p got %p", want, seg);
        end
      end
    end
  end

  task automatic add_range(brn_pkg::ofs_t d, brn_pkg::ofs_t l, brn_pkg::ofs_t s, logic last);
    brn_pkg::rng_t r;
    r = '{dst_ofs: d, length: l, src_ofs: s, last_range: last};
    range_q.insert(range_q.size(), r);
    ranges_queued++;
  endtask

  // mostly a tiling of a random stretch of [0, total] with random content, plus gaps,
  // zero-length entries, contained sub-ranges and the odd garbage range
  task automatic add_random_set(brn_pkg::ofs_t limit);
    logic [63:0]   cuts[$];
    brn_pkg::rng_t items[$];
    brn_pkg::rng_t t;
    logic [63:0]   len, off;
    int            k, roll, j;
    k = ($urandom_range(0, 11) == 0) ? $urandom_range(17, 19) : $urandom_range(1, 14);
    for (int i = 0; i <= k; i++) cuts.insert(cuts.size(), {16'd0, rand48()} % (64'(limit) + 1));
    cuts.sort();
    for (int i = 0; i < k; i++) begin
      t.dst_ofs = brn_pkg::ofs_t'(cuts[i]);
      len = cuts[i+1] - cuts[i];
      t.src_ofs = rand48();
      t.last_range = 1'b0;
      roll = $urandom_range(0, 9);
      if (roll == 0) len = 0;
      if (roll == 1 && len > 1) len = len - ({16'd0, rand48()} % len);
      t.length = brn_pkg::ofs_t'(len);
      if (roll == 2) begin
        t.dst_ofs = rand48();
        t.length = rand48();
      end
      items.insert(items.size(), t);
      if (roll == 3 && len > 0) begin
        off = {16'd0, rand48()} % len;
        t.dst_ofs = brn_pkg::ofs_t'(cuts[i] + off);
        t.length = brn_pkg::ofs_t'({16'd0, rand48()} % (len - off) + 1);
        t.src_ofs = brn_pkg::ofs_t'(items[items.size()-1].src_ofs + off);
        items.insert(items.size(), t);
      end
    end
    for (int i = items.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = items[i];
      items[i] = items[j];
      items[j] = t;
    end
    items[items.size()-1].last_range = 1'b1;
    foreach (items[i]) add_range(items[i].dst_ofs, items[i].length,
                                 items[i].src_ofs, items[i].last_range);
  endtask

  // wait until every range is taken and every segment has come out
  task automatic drain();
    while (ranges_taken != ranges_queued || segment_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_total(brn_pkg::ofs_t v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    space_len = v;
  endtask

  initial begin
    brn_pkg::ofs_t limit;
    int            made;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset total of one byte: exact fit, zero-length only, out of bounds
    add_range(0, 1, OFS_MAX, 1'b1);
    add_range(5, 0, 7, 1'b1);
    add_range(1, 1, 0, 1'b1);

    write_total(100);
    // trimmed source wrapping past the top of the offset space
    add_range(0, 10, OFS_MAX - 7, 1'b0);
    add_range(5, 20, OFS_MAX - 2, 1'b1);
    // equal destination and source, shorter goes first
    add_range(50, 9, 7, 1'b0);
    add_range(50, 5, 7, 1'b1);
    // conflicting overlap, then length running past the end
    add_range(70, 10, 0, 1'b0);
    add_range(75, 10, 999, 1'b1);
    add_range(90, 11, 3, 1'b1);
    // too many ranges, zero-length ones count too
    for (int i = 0; i < MAX_RANGES + 1; i++)
      add_range(brn_pkg::ofs_t'(i * 5), brn_pkg::ofs_t'(i % 3), brn_pkg::ofs_t'(i),
                i == MAX_RANGES);

    write_total(OFS_MAX);
    add_range(0, OFS_MAX, 0, 1'b1);
    add_range(OFS_MAX - 1, 1, OFS_MAX, 1'b1);

    // random phases over several totals, extremes included
    made = 0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: limit = 1;
        1: limit = OFS_MAX;
        2, 4: limit = brn_pkg::ofs_t'($urandom_range(1, 300));
        default: limit = rand48() | 1;
      endcase
      write_total(limit);
      while (made < (ph + 1) * 42) begin
        add_random_set(limit);
        made = ranges_queued;
      end
    end

    drain();
    if (segment_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("[byte_range_normalizer] OK");
    end else begin
      $display("[byte_range_normalizer] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[byte_range_normalizer] ERROR");
    $finish;
  end

endmodule
